// File: sv/prle_pkg.sv
package prle_pkg;

  localparam int BYTE_W        = 8;
  localparam int MAX_GROUP_DEF = 128;
  localparam int SEG_SLOTS     = 3;
  localparam int SEG_CANDS     = 5;
  localparam int WORD_BYTES    = 4;
  localparam int OUT_CNT_W     = 3;
  localparam int OUT_TDATA_W   = 40;

  localparam logic [BYTE_W-1:0] END_MARKER   = 8'd128;
  localparam logic [BYTE_W:0]   RUN_HDR_BASE = 9'd257;

  // pending group kind; code 3 never arises and decodes as idle
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_LIT  = 2'd1,
    MODE_RUN  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SEG_NONE,
    SEG_LIT,
    SEG_RUN,
    SEG_END
  } seg_kind_t;

  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_VAL,
    SRC_LIT
  } byte_src_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_BODY
  } ctl_state_t;

  typedef struct packed {
    logic      accept;     // capture input beat, build segment queue
    logic      push;       // offer one code byte to the packer
    byte_src_t src;
    logic      push_last;  // byte closes this beat's output burst
    logic      seg_pop;    // current segment done
  } dp_cmd_t;

  typedef struct packed {
    seg_kind_t kind;          // head of segment queue
    seg_kind_t next_kind;
    logic      lit_last;      // literal read pointer at final byte
    logic      out_room;      // output register free this cycle
    logic      asm_near_full; // packer holds three bytes
  } dp_status_t;

endpackage

// File: sv/prle_ctrl.sv
module prle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  prle_pkg::dp_status_t status,
  output prle_pkg::dp_cmd_t    cmd
);

  prle_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prle_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic seg_end;
    logic ok;
    state_next    = state;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.src       = prle_pkg::SRC_HDR;
    seg_end       = 1'b0;
    ok            = 1'b0;
    unique case (state)
      prle_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = prle_pkg::ST_HDR;
        end
      end
      prle_pkg::ST_HDR: begin
        if (status.kind == prle_pkg::SEG_NONE) begin
          state_next = prle_pkg::ST_IDLE;
        end else begin
          cmd.push      = 1'b1;
          cmd.src       = prle_pkg::SRC_HDR;
          cmd.push_last = (status.kind == prle_pkg::SEG_END);
          ok = status.out_room || (!status.asm_near_full && !cmd.push_last);
          if (ok) begin
            if (status.kind == prle_pkg::SEG_END) begin
              cmd.seg_pop = 1'b1;
              state_next  = prle_pkg::ST_IDLE;
            end else begin
              state_next = prle_pkg::ST_BODY;
            end
          end
        end
      end
      prle_pkg::ST_BODY: begin
        cmd.push      = 1'b1;
        cmd.src       = (status.kind == prle_pkg::SEG_RUN) ? prle_pkg::SRC_VAL
                                                           : prle_pkg::SRC_LIT;
        seg_end       = (status.kind == prle_pkg::SEG_RUN) || status.lit_last;
        cmd.push_last = seg_end && (status.next_kind == prle_pkg::SEG_NONE);
        ok = status.out_room || (!status.asm_near_full && !cmd.push_last);
        if (ok && seg_end) begin
          cmd.seg_pop = 1'b1;
          state_next  = (status.next_kind == prle_pkg::SEG_NONE) ? prle_pkg::ST_IDLE
                                                                 : prle_pkg::ST_HDR;
        end
      end
      default: begin
        state_next = prle_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/prle_dp.sv
module prle_dp #(
  parameter int MAX_GROUP = prle_pkg::MAX_GROUP_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  prle_pkg::dp_cmd_t           cmd,
  output prle_pkg::dp_status_t        status,
  input  logic [prle_pkg::BYTE_W-1:0] in_byte,
  input  logic                        in_last,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [prle_pkg::BYTE_W-1:0] out_byte [prle_pkg::WORD_BYTES],
  output logic [prle_pkg::OUT_CNT_W-1:0] out_cnt,
  output logic                        out_last,
  output logic                        out_end
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int IDX_W = $clog2(MAX_GROUP);
  localparam bit RUN_FULL_AT_TWO = (MAX_GROUP <= 2);

  // group state
  prle_pkg::mode_t             mode, mode_n;
  logic [CNT_W-1:0]            lit_cnt, cnt_n;
  logic [CNT_W-1:0]            run_len, rl_n;
  logic [prle_pkg::BYTE_W-1:0] run_val, rv_n;
  logic [prle_pkg::BYTE_W-1:0] last_lit, ll_n;

  // literal buffer
  logic [prle_pkg::BYTE_W-1:0] lit_mem [MAX_GROUP];
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_wa;
  logic [prle_pkg::BYTE_W-1:0] mem_wd;
  logic [CNT_W-1:0]            rd_ptr, rd_ptr_next;
  logic [IDX_W-1:0]            rd_idx_next;
  logic [prle_pkg::BYTE_W-1:0] rd_q;

  // accept-time decode
  logic                        a_lit, a_run, f_lit, f_run;
  logic                        wr_req;
  logic [CNT_W-1:0]            lit_n, rlen_e;
  logic [prle_pkg::BYTE_W-1:0] rval_e;
  logic [CNT_W-1:0]            cnt_inc, rl_inc;
  prle_pkg::seg_kind_t         cand   [prle_pkg::SEG_CANDS];
  prle_pkg::seg_kind_t         slot_n [prle_pkg::SEG_SLOTS];
  logic [1:0]                  fill;

  // segment queue and emit descriptors
  prle_pkg::seg_kind_t         seg_slot [prle_pkg::SEG_SLOTS];
  logic [CNT_W-1:0]            e_lit_len;
  logic [prle_pkg::BYTE_W-1:0] e_lit_hdr, e_run_hdr, e_run_val;

  // packer
  logic [prle_pkg::BYTE_W-1:0] asm_byte [prle_pkg::WORD_BYTES];
  logic [1:0]                  asm_cnt;
  logic                        push_ok, push_fire, completing, push_is_end;
  logic [prle_pkg::BYTE_W-1:0] push_byte, hdr_byte;

  assign cnt_inc = lit_cnt + CNT_W'(1);
  assign rl_inc  = run_len + CNT_W'(1);

  always_comb begin
    a_lit  = 1'b0;
    a_run  = 1'b0;
    f_lit  = 1'b0;
    f_run  = 1'b0;
    wr_req = 1'b0;
    mem_wa = '0;
    mem_wd = in_byte;
    lit_n  = lit_cnt;
    rlen_e = run_len;
    rval_e = run_val;
    mode_n = mode;
    cnt_n  = lit_cnt;
    rl_n   = run_len;
    rv_n   = run_val;
    ll_n   = last_lit;
    unique case (mode)
      prle_pkg::MODE_LIT: begin
        if (in_byte == last_lit) begin
          // repeat: close literal before its last byte, that byte opens a run
          a_lit  = (lit_cnt >= CNT_W'(2));
          lit_n  = lit_cnt - CNT_W'(1);
          cnt_n  = '0;
          rv_n   = in_byte;
          rl_n   = CNT_W'(2);
          mode_n = prle_pkg::MODE_RUN;
          if (RUN_FULL_AT_TWO) begin
            a_run  = 1'b1;
            rlen_e = CNT_W'(2);
            rval_e = in_byte;
            mode_n = prle_pkg::MODE_IDLE;
          end
        end else begin
          wr_req = 1'b1;
          mem_wa = lit_cnt[IDX_W-1:0];
          ll_n   = in_byte;
          cnt_n  = cnt_inc;
          if (cnt_inc >= CNT_W'(MAX_GROUP)) begin
            a_lit  = 1'b1;
            lit_n  = cnt_inc;
            cnt_n  = '0;
            mode_n = prle_pkg::MODE_IDLE;
          end
        end
      end
      prle_pkg::MODE_RUN: begin
        if (in_byte == run_val) begin
          rl_n = rl_inc;
          if (rl_inc >= CNT_W'(MAX_GROUP)) begin
            a_run  = 1'b1;
            rlen_e = rl_inc;
            mode_n = prle_pkg::MODE_IDLE;
          end
        end else begin
          a_run  = 1'b1;
          wr_req = 1'b1;
          ll_n   = in_byte;
          cnt_n  = CNT_W'(1);
          mode_n = prle_pkg::MODE_LIT;
        end
      end
      default: begin
        wr_req = 1'b1;
        ll_n   = in_byte;
        cnt_n  = CNT_W'(1);
        mode_n = prle_pkg::MODE_LIT;
      end
    endcase
    // end of stream: flush whatever is open
    if (in_last) begin
      if (mode_n == prle_pkg::MODE_LIT) begin
        f_lit = 1'b1;
        lit_n = cnt_n;
      end else if (mode_n == prle_pkg::MODE_RUN) begin
        f_run  = 1'b1;
        rlen_e = rl_n;
        rval_e = rv_n;
      end
      cnt_n  = '0;
      mode_n = prle_pkg::MODE_IDLE;
    end
  end

  // pack present segments into the queue in stream order
  always_comb begin
    cand[0] = a_lit   ? prle_pkg::SEG_LIT : prle_pkg::SEG_NONE;
    cand[1] = a_run   ? prle_pkg::SEG_RUN : prle_pkg::SEG_NONE;
    cand[2] = f_lit   ? prle_pkg::SEG_LIT : prle_pkg::SEG_NONE;
    cand[3] = f_run   ? prle_pkg::SEG_RUN : prle_pkg::SEG_NONE;
    cand[4] = in_last ? prle_pkg::SEG_END : prle_pkg::SEG_NONE;
    for (int s = 0; s < prle_pkg::SEG_SLOTS; s++) begin
      slot_n[s] = prle_pkg::SEG_NONE;
    end
    fill = '0;
    for (int c = 0; c < prle_pkg::SEG_CANDS; c++) begin
      if (cand[c] != prle_pkg::SEG_NONE && fill < 2'(prle_pkg::SEG_SLOTS)) begin
        slot_n[fill] = cand[c];
        fill         = fill + 2'd1;
      end
    end
  end

  assign mem_we = cmd.accept && wr_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= prle_pkg::MODE_IDLE;
      lit_cnt <= '0;
      run_len <= '0;
      run_val <= '0;
    end else if (cmd.accept) begin
      mode    <= mode_n;
      lit_cnt <= cnt_n;
      run_len <= rl_n;
      run_val <= rv_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      last_lit  <= ll_n;
      e_lit_len <= lit_n;
      e_lit_hdr <= prle_pkg::BYTE_W'(lit_n) - prle_pkg::BYTE_W'(1);
      e_run_hdr <= prle_pkg::BYTE_W'(prle_pkg::RUN_HDR_BASE
                                     - (prle_pkg::BYTE_W + 1)'(rlen_e));
      e_run_val <= rval_e;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < prle_pkg::SEG_SLOTS; s++) begin
        seg_slot[s] <= prle_pkg::SEG_NONE;
      end
    end else if (cmd.accept) begin
      seg_slot <= slot_n;
    end else if (cmd.seg_pop) begin
      for (int s = 0; s < prle_pkg::SEG_SLOTS - 1; s++) begin
        seg_slot[s] <= seg_slot[s+1];
      end
      seg_slot[prle_pkg::SEG_SLOTS-1] <= prle_pkg::SEG_NONE;
    end
  end

  // literal read port: rd_q always tracks lit_mem[rd_ptr], write-first
  always_comb begin
    rd_ptr_next = rd_ptr;
    if (cmd.accept) begin
      rd_ptr_next = '0;
    end else if (push_fire && cmd.src == prle_pkg::SRC_LIT) begin
      rd_ptr_next = rd_ptr + CNT_W'(1);
    end
  end

  assign rd_idx_next = rd_ptr_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lit_mem[mem_wa] <= mem_wd;
    end
    if (mem_we && mem_wa == rd_idx_next) begin
      rd_q <= mem_wd;
    end else begin
      rd_q <= lit_mem[rd_idx_next];
    end
  end

  // byte source
  always_comb begin
    case (seg_slot[0])
      prle_pkg::SEG_LIT: hdr_byte = e_lit_hdr;
      prle_pkg::SEG_RUN: hdr_byte = e_run_hdr;
      default:           hdr_byte = prle_pkg::END_MARKER;
    endcase
    case (cmd.src)
      prle_pkg::SRC_VAL: push_byte = e_run_val;
      prle_pkg::SRC_LIT: push_byte = rd_q;
      default:           push_byte = hdr_byte;
    endcase
  end

  assign push_is_end = (cmd.src == prle_pkg::SRC_HDR) && (seg_slot[0] == prle_pkg::SEG_END);
  assign push_ok     = !out_valid || out_ready || (asm_cnt != 2'd3 && !cmd.push_last);
  assign push_fire   = cmd.push && push_ok;
  assign completing  = push_fire && (asm_cnt == 2'd3 || cmd.push_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (completing) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (push_fire) begin
        asm_cnt <= completing ? 2'd0 : asm_cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire && !completing) begin
      asm_byte[asm_cnt] <= push_byte;
    end
    if (completing) begin
      for (int k = 0; k < prle_pkg::WORD_BYTES; k++) begin
        if (2'(k) < asm_cnt) begin
          out_byte[k] <= asm_byte[k];
        end else if (2'(k) == asm_cnt) begin
          out_byte[k] <= push_byte;
        end else begin
          out_byte[k] <= '0;
        end
      end
      out_cnt  <= {1'b0, asm_cnt} + prle_pkg::OUT_CNT_W'(1);
      out_last <= cmd.push_last;
      out_end  <= push_is_end;
    end
  end

  assign status.kind          = seg_slot[0];
  assign status.next_kind     = seg_slot[1];
  assign status.lit_last      = ((rd_ptr + CNT_W'(1)) == e_lit_len);
  assign status.out_room      = !out_valid || out_ready;
  assign status.asm_near_full = (asm_cnt == 2'd3);

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cnt != '0 && out_cnt <= prle_pkg::OUT_CNT_W'(prle_pkg::WORD_BYTES)))
    else $error("word byte count out of range");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_end) |-> out_last)
    else $error("end marker word not closing its burst");
  a_lit_cnt: assert property (@(posedge clk) disable iff (rst)
    (mode == prle_pkg::MODE_LIT) |->
      (lit_cnt >= CNT_W'(1) && lit_cnt < CNT_W'(MAX_GROUP)))
    else $error("open literal group has bad count");
  a_lit_clear: assert property (@(posedge clk) disable iff (rst)
    (mode != prle_pkg::MODE_LIT) |-> (lit_cnt == '0))
    else $error("literal count left over outside literal mode");
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    (mode == prle_pkg::MODE_RUN) |->
      (run_len >= CNT_W'(2) && run_len < CNT_W'(MAX_GROUP)))
    else $error("open run has bad length");
`endif

endmodule

// File: sv/packbits_run_length_encoder.sv
// PackBits encoder: raw bytes in, code bytes out packed up to four per beat.
// Timing: an input beat is taken in ST_IDLE; its code bytes then enter the packer one per
//   cycle unless m_tready stalls; a word shows on m_tvalid the cycle after its last byte.
// Input flow: s_tready is high only in ST_IDLE, so the next beat is taken only after all
//   code bytes of the previous one have entered the packer; m_tready stalls can hold it.
// Reset: synchronous, active high; clears group state, segment queue and output valid.
module packbits_run_length_encoder #(
  parameter int MAX_GROUP = prle_pkg::MAX_GROUP_DEF  // longest run or literal group, 2..128
) (
  input  logic                             clk,
  input  logic                             rst,
  // raw byte stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [prle_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                             s_tlast,   // last_byte
  // packed code stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [prle_pkg::OUT_TDATA_W-1:0] m_tdata,   // out_byte0, out_byte1, out_byte2,
                                                      // out_byte3, byte_count[34:32], pad
  output logic                             m_tlast,   // burst_last
  output logic [0:0]                       m_tuser    // stream_end
);

  prle_pkg::dp_cmd_t           cmd;
  prle_pkg::dp_status_t        status;
  logic [prle_pkg::BYTE_W-1:0] out_byte [prle_pkg::WORD_BYTES];
  logic [prle_pkg::OUT_CNT_W-1:0] out_cnt;
  logic                        out_end;

  // sequencer: walks the segment queue (literal, run, end marker) one beat at a time
  prle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // group tracking, literal buffer, code byte mux and word packer
  // literal buffer is not cleared; only entries written since reset are ever read
  prle_dp #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_byte  (out_byte),
    .out_cnt   (out_cnt),
    .out_last  (m_tlast),
    .out_end   (out_end)
  );

  // bytes in stream order from the low end, count above, zero pad to 40 bits
  assign m_tdata = {5'b0, out_cnt, out_byte[3], out_byte[2], out_byte[1], out_byte[0]};
  assign m_tuser = out_end;

endmodule
